// ===== hdl/rgbh_pkg.sv =====
// Shared types, codes and defaults for the RGB histogram engine.
package rgbh_pkg;

  localparam int MAX_BINS_DEF   = 256;
  localparam int COUNT_BITS_DEF = 24;
  localparam int TOTAL_W        = 24;
  localparam int BIN_COUNT_W    = 9;
  localparam int APB_ADDR_W     = 2;
  localparam int APB_DATA_W     = 32;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic KIND_REPORT   = 1'b0;
  localparam logic KIND_READBACK = 1'b1;

  localparam logic [APB_ADDR_W-1:0] REG_BIN_COUNT = 2'd0;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
    logic [7:0] read_bin;
  } hist_item_t;

  typedef struct packed {
    logic               result_kind;
    logic [TOTAL_W-1:0] red_total;
    logic [TOTAL_W-1:0] green_total;
    logic [TOTAL_W-1:0] blue_total;
    logic [TOTAL_W-1:0] peak_total;
  } hist_result_t;

endpackage

// ===== hdl/rgbh_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module rgbh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rgbh_bin_map.sv =====
// Maps one color byte to its histogram bin: (value * bins) >> 8.
module rgbh_bin_map #(
  parameter int MAX_BINS = rgbh_pkg::MAX_BINS_DEF,
  parameter int ADDR_W   = 8
) (
  input  logic [7:0]                          value,
  input  logic [rgbh_pkg::BIN_COUNT_W-1:0]    bin_count,
  output logic [ADDR_W-1:0]                   bin
);

  localparam logic [rgbh_pkg::BIN_COUNT_W-1:0] MaxN = rgbh_pkg::BIN_COUNT_W'(MAX_BINS);

  logic [rgbh_pkg::BIN_COUNT_W-1:0]   n;
  logic [rgbh_pkg::BIN_COUNT_W+7:0]   prod;

  always_comb begin
    // clamp the bin count to the physical depth
    n    = (bin_count > MaxN) ? MaxN : bin_count;
    prod = {{rgbh_pkg::BIN_COUNT_W{1'b0}}, value} * {8'd0, n};
  end

  // quotient is below the clamped count (or zero if that count is zero), so truncation is exact
  assign bin = prod[8 +: ADDR_W];

endmodule

// ===== hdl/rgbh_update.sv =====
// Saturating count increment for three channels and running peak update.
module rgbh_update #(
  parameter int COUNT_BITS = rgbh_pkg::COUNT_BITS_DEF
) (
  input  logic [COUNT_BITS-1:0] red_cnt,
  input  logic [COUNT_BITS-1:0] green_cnt,
  input  logic [COUNT_BITS-1:0] blue_cnt,
  input  logic [COUNT_BITS-1:0] peak,
  output logic [COUNT_BITS-1:0] red_new,
  output logic [COUNT_BITS-1:0] green_new,
  output logic [COUNT_BITS-1:0] blue_new,
  output logic [COUNT_BITS-1:0] peak_new
);

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] m_rg;
  logic [COUNT_BITS-1:0] m_b;

  always_comb begin
    red_new   = (red_cnt   == CountMax) ? red_cnt   : red_cnt   + 1'b1;
    green_new = (green_cnt == CountMax) ? green_cnt : green_cnt + 1'b1;
    blue_new  = (blue_cnt  == CountMax) ? blue_cnt  : blue_cnt  + 1'b1;
    m_rg      = (red_new > green_new) ? red_new : green_new;
    m_b       = (blue_new > peak) ? blue_new : peak;
    peak_new  = (m_rg > m_b) ? m_rg : m_b;
  end

endmodule

// ===== hdl/rgb_histogram_engine.sv =====
// Top level of the RGB histogram engine: control, config register and bin RAMs.
//
// Usage: present an item on in_data and raise start; it is taken at a clock
// edge where start is high and busy is low. Operations: clear all bins,
// add a pixel, read back one bin. Results appear on out_data for one cycle
// with out_strobe high; the receiver cannot stall them.
// Pixel and read: the bin RAMs are read at the accepting edge, then the
// write-back state follows; the result of a read, or of a pixel marked last,
// is on out_data in the same cycle in which busy drops.
// Clear: one entry per cycle is zeroed in all three bin RAMs.
// Reset (rst_n low, synchronous) sets bin_count to 1, clears the peak and
// starts the same clearing sweep; busy stays high until the sweep ends.
// bin_count sits at APB byte address 0; it may be written while idle and
// does not clear the bins. Bins never written read back as zero.
module rgb_histogram_engine #(
  parameter int MAX_BINS   = rgbh_pkg::MAX_BINS_DEF,
  parameter int COUNT_BITS = rgbh_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  rgbh_pkg::hist_item_t            in_data,
  output logic                            out_strobe,
  output rgbh_pkg::hist_result_t          out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rgbh_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rgbh_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rgbh_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BINS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_RMW   = 2'd2;

  logic [1:0]                         state_r, state_nxt;
  logic [ADDR_W-1:0]                  clr_addr_r, clr_addr_nxt;
  logic [rgbh_pkg::BIN_COUNT_W-1:0]   bin_count_r;
  logic [COUNT_BITS-1:0]              peak_r, peak_nxt;
  logic                               out_strobe_r, out_strobe_nxt;
  rgbh_pkg::hist_result_t             out_data_r, out_data_nxt;

  logic [1:0]                         op_r;
  logic                               last_r;
  logic                               oob_r;
  logic [ADDR_W-1:0]                  red_addr_r, green_addr_r, blue_addr_r;

  logic                               accept;
  logic                               cfg_write;
  logic [ADDR_W-1:0]                  red_map, green_map, blue_map;
  logic [ADDR_W-1:0]                  red_raddr, green_raddr, blue_raddr;
  logic [COUNT_BITS-1:0]              red_q, green_q, blue_q;
  logic [COUNT_BITS-1:0]              red_new, green_new, blue_new, peak_upd;
  logic                               ram_we;
  logic                               clearing;
  logic [ADDR_W-1:0]                  red_waddr, green_waddr, blue_waddr;
  logic [COUNT_BITS-1:0]              red_wdata, green_wdata, blue_wdata;
  logic [31:0]                        red_ext, green_ext, blue_ext, peak_ext;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == rgbh_pkg::REG_BIN_COUNT);
  assign prdata    = (paddr == rgbh_pkg::REG_BIN_COUNT)
                   ? {{(rgbh_pkg::APB_DATA_W - rgbh_pkg::BIN_COUNT_W){1'b0}}, bin_count_r}
                   : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= rgbh_pkg::BIN_COUNT_W'(1);
    end else if (cfg_write) begin
      bin_count_r <= pwdata[rgbh_pkg::BIN_COUNT_W-1:0];
    end
  end

  rgbh_bin_map #(.MAX_BINS(MAX_BINS), .ADDR_W(ADDR_W)) u_map_red (
    .value(in_data.red), .bin_count(bin_count_r), .bin(red_map)
  );
  rgbh_bin_map #(.MAX_BINS(MAX_BINS), .ADDR_W(ADDR_W)) u_map_green (
    .value(in_data.green), .bin_count(bin_count_r), .bin(green_map)
  );
  rgbh_bin_map #(.MAX_BINS(MAX_BINS), .ADDR_W(ADDR_W)) u_map_blue (
    .value(in_data.blue), .bin_count(bin_count_r), .bin(blue_map)
  );

  // read address: mapped bins for a pixel, the requested bin for a readback
  always_comb begin
    if (in_data.operation == rgbh_pkg::OP_READ) begin
      red_raddr   = in_data.read_bin[ADDR_W-1:0];
      green_raddr = in_data.read_bin[ADDR_W-1:0];
      blue_raddr  = in_data.read_bin[ADDR_W-1:0];
    end else begin
      red_raddr   = red_map;
      green_raddr = green_map;
      blue_raddr  = blue_map;
    end
  end

  // hold the transaction's fields for the write-back cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= in_data.operation;
      last_r       <= in_data.last_pixel;
      oob_r        <= ({1'b0, in_data.read_bin} >= 9'(MAX_BINS));
      red_addr_r   <= red_map;
      green_addr_r <= green_map;
      blue_addr_r  <= blue_map;
    end
  end

  rgbh_update #(.COUNT_BITS(COUNT_BITS)) u_update (
    .red_cnt(red_q), .green_cnt(green_q), .blue_cnt(blue_q), .peak(peak_r),
    .red_new(red_new), .green_new(green_new), .blue_new(blue_new), .peak_new(peak_upd)
  );

  assign clearing    = (state_r == ST_CLEAR);
  assign ram_we      = clearing || (state_r == ST_RMW && op_r == rgbh_pkg::OP_PIXEL);
  assign red_waddr   = clearing ? clr_addr_r : red_addr_r;
  assign green_waddr = clearing ? clr_addr_r : green_addr_r;
  assign blue_waddr  = clearing ? clr_addr_r : blue_addr_r;
  assign red_wdata   = clearing ? '0 : red_new;
  assign green_wdata = clearing ? '0 : green_new;
  assign blue_wdata  = clearing ? '0 : blue_new;

  rgbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_BINS)) u_ram_red (
    .clk(clk), .we(ram_we), .waddr(red_waddr), .wdata(red_wdata),
    .raddr(red_raddr), .rdata(red_q)
  );
  rgbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_BINS)) u_ram_green (
    .clk(clk), .we(ram_we), .waddr(green_waddr), .wdata(green_wdata),
    .raddr(green_raddr), .rdata(green_q)
  );
  rgbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_BINS)) u_ram_blue (
    .clk(clk), .we(ram_we), .waddr(blue_waddr), .wdata(blue_wdata),
    .raddr(blue_raddr), .rdata(blue_q)
  );

  assign red_ext   = 32'(red_q);
  assign green_ext = 32'(green_q);
  assign blue_ext  = 32'(blue_q);
  assign peak_ext  = 32'(peak_upd);

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    peak_nxt       = peak_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.operation) inside
            rgbh_pkg::OP_CLEAR: begin
              state_nxt    = ST_CLEAR;
              clr_addr_nxt = '0;
              peak_nxt     = '0;
            end
            rgbh_pkg::OP_PIXEL, rgbh_pkg::OP_READ: begin
              state_nxt = ST_RMW;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RMW: begin
        state_nxt = ST_IDLE;
        if (op_r == rgbh_pkg::OP_PIXEL) begin
          peak_nxt = peak_upd;
          if (last_r) begin
            out_strobe_nxt           = 1'b1;
            out_data_nxt.result_kind = rgbh_pkg::KIND_REPORT;
            out_data_nxt.red_total   = '0;
            out_data_nxt.green_total = '0;
            out_data_nxt.blue_total  = '0;
            out_data_nxt.peak_total  = peak_ext[rgbh_pkg::TOTAL_W-1:0];
          end
        end else begin
          out_strobe_nxt           = 1'b1;
          out_data_nxt.result_kind = rgbh_pkg::KIND_READBACK;
          out_data_nxt.red_total   = oob_r ? '0 : red_ext[rgbh_pkg::TOTAL_W-1:0];
          out_data_nxt.green_total = oob_r ? '0 : green_ext[rgbh_pkg::TOTAL_W-1:0];
          out_data_nxt.blue_total  = oob_r ? '0 : blue_ext[rgbh_pkg::TOTAL_W-1:0];
          out_data_nxt.peak_total  = 24'(32'(peak_r));
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      peak_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      peak_r       <= peak_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

`ifndef NO_ASSERTIONS
  // a result only follows a write-back cycle, and the block is idle again
  a_strobe_after_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> ($past(state_r) == ST_RMW) && (state_r == ST_IDLE))
    else $error("result strobe without preceding write-back");

  // the peak only drops through a clear transaction
  a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (peak_r < $past(peak_r)))
      |-> $past(accept && (in_data.operation == rgbh_pkg::OP_CLEAR)))
    else $error("peak decreased without clear");

  // bin RAMs are only written while a transaction or the clearing sweep is active
  a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> busy)
    else $error("bin RAM written while idle");
`endif

endmodule
